// ===== rtl/ppcl_pkg.sv =====
// ----------------------------------------------------------------------------
// ppcl_pkg
// Shared types, sizes and codes for the pin/power correlation log.
// ----------------------------------------------------------------------------
package ppcl_pkg;

  localparam int LOG_DEPTH = 256;
  localparam int NUM_PINS  = 12;
  localparam int HALF      = LOG_DEPTH / 2;
  localparam int IDX_W     = $clog2(LOG_DEPTH);
  localparam int CNT_W     = IDX_W + 1;
  localparam int MV_W      = 13;
  localparam int PS_W      = 24;
  localparam int PIX_W     = 4;
  localparam int SUM_W     = MV_W + IDX_W;
  localparam int DIVC_W    = $clog2(SUM_W + 1);

  // func codes
  localparam logic [1:0] FN_REC = 2'd0;
  localparam logic [1:0] FN_ANA = 2'd1;
  localparam logic [1:0] FN_CLR = 2'd2;

  // result kinds
  localparam logic [1:0] K_ACK  = 2'd0;
  localparam logic [1:0] K_CAND = 2'd1;
  localparam logic [1:0] K_SUM  = 2'd2;

  typedef struct packed {
    logic [1:0]      func;
    logic            usb_present;
    logic [MV_W-1:0] batt_mv;
    logic [PS_W-1:0] pin_states;
  } in_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [PIX_W-1:0] pin_index;
    logic [1:0]       state_plugged;
    logic [1:0]       state_unplugged;
    logic [MV_W-1:0]  avg_mv_plugged;
    logic [MV_W-1:0]  avg_mv_unplugged;
    logic [CNT_W-1:0] entries;
    logic             halved;
    logic             last;
  } out_t;

  typedef struct packed {
    logic [PS_W-1:0] pins;
    logic [MV_W-1:0] mv;
    logic            usb;
  } smp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic cnt_clr;
    logic seq_clr;
    logic dec_step;
    logic wr_rec;
    logic scan_step;
    logic div_start;
    logic div_sel;
    logic emit_ack;
    logic cand_step;
    logic emit_sum;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic dec_done;
    logic scan_done;
    logic div_busy;
    logic last_pin;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/ppcl_ctrl.sv =====
// ----------------------------------------------------------------------------
// ppcl_ctrl
// Sequencer: record, decimate, scan, divide and emit phases.
// ----------------------------------------------------------------------------
module ppcl_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [1:0]     in_func,
  output logic           in_ready,
  input  ppcl_pkg::sts_t sts,
  output ppcl_pkg::cmd_t cmd
);
  import ppcl_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_WR    = 4'd2;
  localparam logic [3:0] S_ACK   = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_DIVP  = 4'd5;
  localparam logic [3:0] S_DIVPW = 4'd6;
  localparam logic [3:0] S_DIVU  = 4'd7;
  localparam logic [3:0] S_DIVUW = 4'd8;
  localparam logic [3:0] S_CAND  = 4'd9;
  localparam logic [3:0] S_SUM   = 4'd10;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load    = 1'b1;
          cmd.seq_clr = 1'b1;
          case (in_func)
            FN_REC: state_nxt = sts.full ? S_DEC : S_WR;
            FN_ANA: state_nxt = S_SCAN;
            FN_CLR: begin
              cmd.cnt_clr = 1'b1;
              state_nxt   = S_ACK;
            end
            default: state_nxt = S_ACK;
          endcase
        end
      end
      S_DEC: begin
        cmd.dec_step = 1'b1;
        if (sts.dec_done) begin
          cmd.seq_clr = 1'b1;
          state_nxt   = S_WR;
        end
      end
      S_WR: begin
        cmd.wr_rec = 1'b1;
        state_nxt  = S_ACK;
      end
      S_ACK: begin
        if (sts.out_free) begin
          cmd.emit_ack = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          cmd.seq_clr = 1'b1;
          state_nxt   = S_DIVP;
        end
      end
      S_DIVP: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b0;
        state_nxt     = S_DIVPW;
      end
      S_DIVPW: begin
        if (!sts.div_busy) state_nxt = S_DIVU;
      end
      S_DIVU: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
        state_nxt     = S_DIVUW;
      end
      S_DIVUW: begin
        if (!sts.div_busy) begin
          cmd.seq_clr = 1'b1;
          state_nxt   = S_CAND;
        end
      end
      S_CAND: begin
        if (sts.out_free) begin
          cmd.cand_step = 1'b1;
          if (sts.last_pin) state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (sts.out_free) begin
          cmd.emit_sum = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/ppcl_dp.sv =====
// ----------------------------------------------------------------------------
// ppcl_dp
// Sample memory, scan window, per-pin masks, sums, divider, result register.
// ----------------------------------------------------------------------------
module ppcl_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  ppcl_pkg::in_t   in_data,
  input  ppcl_pkg::cmd_t  cmd,
  output ppcl_pkg::sts_t  sts,
  input  logic            out_ready,
  output logic            out_valid,
  output ppcl_pkg::out_t  out_data
);
  import ppcl_pkg::*;

  function automatic logic is_sole(input logic [3:0] m);
    return (m != 4'd0) && ((m & (m - 4'd1)) == 4'd0);
  endfunction

  function automatic logic [1:0] enc(input logic [3:0] m);
    logic [1:0] r;
    case (m)
      4'b0010: r = 2'd1;
      4'b0100: r = 2'd2;
      4'b1000: r = 2'd3;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  in_t              item_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] seq_r;
  logic             halved_r;

  smp_t             mem [LOG_DEPTH];
  smp_t             rd_data_r;
  logic [CNT_W-1:0] rd_idx_r;
  logic             rd_vld_r;

  logic             prev_usb_r;
  smp_t             mid_r;
  logic [3:0]       pm_r [NUM_PINS];
  logic [3:0]       um_r [NUM_PINS];
  logic [SUM_W-1:0] psum_r, usum_r;
  logic [CNT_W-1:0] pn_r, un_r;

  logic             div_busy_r, div_sel_r;
  logic [SUM_W-1:0] div_q_r;
  logic [CNT_W-1:0] div_rem_r, div_d_r;
  logic [DIVC_W-1:0] div_cnt_r;
  logic [MV_W-1:0]  avg_p_r, avg_u_r;

  logic             out_valid_r;
  out_t             out_data_r;

  // memory port control
  logic             mem_we, mem_re, dec_rd, scan_rd;
  logic [IDX_W-1:0] mem_wa, mem_ra;
  smp_t             mem_wd, rec_smp;
  logic [CNT_W-1:0] seq_m1;

  always_comb begin
    rec_smp = '{pins: item_r.pin_states, mv: item_r.batt_mv, usb: item_r.usb_present};
    seq_m1  = seq_r - 1'b1;
    dec_rd  = cmd.dec_step && (seq_r < CNT_W'(HALF));
    scan_rd = cmd.scan_step && (seq_r < count_r);
    mem_we  = (cmd.dec_step && (seq_r != '0)) || cmd.wr_rec;
    mem_wa  = cmd.wr_rec ? count_r[IDX_W-1:0] : seq_m1[IDX_W-1:0];
    mem_wd  = cmd.wr_rec ? rec_smp : rd_data_r;
    mem_re  = dec_rd || scan_rd;
    mem_ra  = cmd.dec_step ? {seq_r[IDX_W-2:0], 1'b0} : seq_r[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data_r <= mem[mem_ra];
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      seq_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= scan_rd;
      if (cmd.seq_clr) begin
        seq_r <= '0;
      end else if (cmd.dec_step || scan_rd || cmd.cand_step) begin
        seq_r <= seq_r + 1'b1;
      end
      if (cmd.cnt_clr) begin
        count_r <= '0;
      end else if (cmd.dec_step && sts.dec_done) begin
        count_r <= CNT_W'(HALF);
      end else if (cmd.wr_rec) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  // item latch, halved flag, scan window and accumulators
  logic settled;
  assign settled = (rd_idx_r >= CNT_W'(2)) && (prev_usb_r == mid_r.usb) &&
                   (rd_data_r.usb == mid_r.usb);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r   <= in_data;
      halved_r <= 1'b0;
      psum_r   <= '0;
      usum_r   <= '0;
      pn_r     <= '0;
      un_r     <= '0;
      for (int p = 0; p < NUM_PINS; p++) begin
        pm_r[p] <= 4'd0;
        um_r[p] <= 4'd0;
      end
    end else begin
      if (cmd.dec_step && sts.dec_done) halved_r <= 1'b1;
      if (rd_vld_r) begin
        if (settled) begin
          if (mid_r.usb) begin
            psum_r <= psum_r + SUM_W'(mid_r.mv);
            pn_r   <= pn_r + 1'b1;
          end else begin
            usum_r <= usum_r + SUM_W'(mid_r.mv);
            un_r   <= un_r + 1'b1;
          end
          for (int p = 0; p < NUM_PINS; p++) begin
            if (mid_r.usb) pm_r[p] <= pm_r[p] | (4'd1 << mid_r.pins[2*p +: 2]);
            else           um_r[p] <= um_r[p] | (4'd1 << mid_r.pins[2*p +: 2]);
          end
        end
        prev_usb_r <= mid_r.usb;
        mid_r      <= rd_data_r;
      end
    end
    if (scan_rd) rd_idx_r <= seq_r;
  end

  // restoring divider, one quotient bit per cycle
  logic [CNT_W:0]   div_trial;
  logic             div_ge;
  logic [CNT_W-1:0] div_rem_nxt, div_d_in;
  logic [SUM_W-1:0] div_q_nxt, div_n_in;

  always_comb begin
    div_trial   = {div_rem_r, div_q_r[SUM_W-1]};
    div_ge      = div_trial >= {1'b0, div_d_r};
    div_rem_nxt = div_ge ? (div_trial[CNT_W-1:0] - div_d_r) : div_trial[CNT_W-1:0];
    div_q_nxt   = {div_q_r[SUM_W-2:0], div_ge};
    div_d_in    = cmd.div_sel ? un_r : pn_r;
    div_n_in    = cmd.div_sel ? usum_r : psum_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy_r <= (div_d_in != '0);
    end else if (div_busy_r && (div_cnt_r == DIVC_W'(1))) begin
      div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_sel_r <= cmd.div_sel;
      div_d_r   <= div_d_in;
      div_q_r   <= div_n_in;
      div_rem_r <= '0;
      div_cnt_r <= DIVC_W'(SUM_W);
      if (div_d_in == '0) begin
        if (cmd.div_sel) avg_u_r <= '0;
        else             avg_p_r <= '0;
      end
    end else if (div_busy_r) begin
      div_q_r   <= div_q_nxt;
      div_rem_r <= div_rem_nxt;
      div_cnt_r <= div_cnt_r - 1'b1;
      if (div_cnt_r == DIVC_W'(1)) begin
        if (div_sel_r) avg_u_r <= div_q_nxt[MV_W-1:0];
        else           avg_p_r <= div_q_nxt[MV_W-1:0];
      end
    end
  end

  // candidate check for the pin under the sequence counter
  logic [3:0] pm_sel, um_sel;
  logic       cand_ok;

  always_comb begin
    pm_sel  = pm_r[seq_r[PIX_W-1:0]];
    um_sel  = um_r[seq_r[PIX_W-1:0]];
    cand_ok = is_sole(pm_sel) && is_sole(um_sel) && (pm_sel != um_sel);
  end

  // result register
  logic emit;
  out_t out_nxt;

  always_comb begin
    emit    = cmd.emit_ack || (cmd.cand_step && cand_ok) || cmd.emit_sum;
    out_nxt = '0;
    out_nxt.entries = count_r;
    if (cmd.emit_ack) begin
      out_nxt.kind   = K_ACK;
      out_nxt.halved = halved_r;
      out_nxt.last   = 1'b1;
    end else if (cmd.emit_sum) begin
      out_nxt.kind             = K_SUM;
      out_nxt.avg_mv_plugged   = avg_p_r;
      out_nxt.avg_mv_unplugged = avg_u_r;
      out_nxt.last             = 1'b1;
    end else begin
      out_nxt.kind            = K_CAND;
      out_nxt.pin_index       = seq_r[PIX_W-1:0];
      out_nxt.state_plugged   = enc(pm_sel);
      out_nxt.state_unplugged = enc(um_sel);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    sts.full      = (count_r == CNT_W'(LOG_DEPTH));
    sts.dec_done  = (seq_r == CNT_W'(HALF));
    sts.scan_done = !(seq_r < count_r) && !rd_vld_r;
    sts.div_busy  = div_busy_r;
    sts.last_pin  = (seq_r == CNT_W'(NUM_PINS - 1));
    sts.out_free  = !out_valid_r || out_ready;
  end

endmodule

// ===== rtl/pin_power_correlation_log.sv =====
// ----------------------------------------------------------------------------
// pin_power_correlation_log
// Sample log of USB flag, battery mV and pin pull states, with decimation
// when full and an analysis pass that reports pins tracking USB power.
// ----------------------------------------------------------------------------
//
//   channel  signals                        payload
//   -------  -----------------------------  --------------------------------
//   in       in_valid / in_ready / in_data  func, usb, mV, 12 pin states
//   out      out_valid / out_ready / out_data  kind, pin, states, avgs, count
//
// Record: one log write, preceded by a decimation sweep when the log is full
//   (one memory read and one write per kept entry). Clear or unused func: acknowledge.
// Analyze: the one-entry-per-cycle log scan, then the shared bit-serial divider
//   run twice, then a candidate check per pin and the summary.
// Reset (rst_n low, synchronous) empties the log; memory contents are kept.
// The result register decouples out_ready: a stalled transaction holds the
//   sequencer in its emit state, never losing or repeating a result.
// in_ready is high only between transactions.
//
module pin_power_correlation_log (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ppcl_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ppcl_pkg::out_t out_data
);
  import ppcl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: decides phases, drives commands
  ppcl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: log memory, analysis accumulators, divider, result register
  ppcl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/ppcl_chk.sv =====
// ----------------------------------------------------------------------------
// ppcl_chk
// Port-level checks for the correlation log, bound to the top level.
// ----------------------------------------------------------------------------
module ppcl_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input ppcl_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input ppcl_pkg::out_t out_data
);
  import ppcl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a transaction is in progress");

  a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == K_ACK || out_data.kind == K_SUM) |-> out_data.last)
    else $error("acknowledge or summary without last");

  a_cand_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == K_CAND |->
      !out_data.last && (out_data.state_plugged != out_data.state_unplugged))
    else $error("malformed candidate");

  a_halved_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.halved |->
      out_data.kind == K_ACK && out_data.entries == CNT_W'(HALF + 1))
    else $error("halved record with wrong count");

endmodule

bind pin_power_correlation_log ppcl_chk u_ppcl_chk (.*);
